// ===== src/lfsm_pkg.sv =====
// Shared types, constants and the mode transition table of the LED fade controller.
`default_nettype none

package lfsm_pkg;

    // Default widths handed to the top level
    localparam int DUTY_WIDTH_DEF = 16;
    localparam int STEP_WIDTH_DEF = 16;
    localparam int FRAC_BITS_DEF  = 10;

    // Fixed field widths
    localparam int PERIOD_W   = 16;
    localparam int REQ_W      = 3;
    localparam int STATE_W    = 2;
    localparam int CFG_ADDR_W = 3;

    // Configuration register indexes
    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_TICK_PERIOD    = 3'd0,
        CFG_FADE_IN_STEPS  = 3'd1,
        CFG_FADE_OFF_STEPS = 3'd2,
        CFG_DUTY_MIN       = 3'd3,
        CFG_DUTY_MAX       = 3'd4
    } t_cfg_addr;

    // LED modes, encoded as reported on led_state
    typedef enum logic [STATE_W-1:0] {
        MODE_OFF      = 2'd0,
        MODE_FADE_IN  = 2'd1,
        MODE_ON       = 2'd2,
        MODE_FADE_OFF = 2'd3
    } t_led_mode;

    // Request codes carried by each tick
    typedef enum logic [REQ_W-1:0] {
        REQ_NONE      = 3'd0,
        REQ_ON        = 3'd1,
        REQ_OFF       = 3'd2,
        REQ_FORCE_ON  = 3'd3,
        REQ_FORCE_OFF = 3'd4
    } t_request;

    // Sequencer states of the top level
    typedef enum logic [2:0] {
        SEQ_IDLE = 3'd0,
        SEQ_STEP = 3'd1,
        SEQ_DIV  = 3'd2,
        SEQ_MUL  = 3'd3,
        SEQ_FIN  = 3'd4,
        SEQ_SEND = 3'd5
    } t_seq_state;

    // Result of a transition table lookup
    typedef struct packed {
        logic      move;
        t_led_mode mode;
    } t_move;

    // Transition table; unknown request codes act as none
    function automatic t_move lookup_move(t_led_mode cur, logic [REQ_W-1:0] req);
        t_move m;
        m.move = 1'b0;
        m.mode = cur;
        unique case (cur)
            MODE_OFF: begin
                case (t_request'(req)) inside
                    REQ_ON:       begin m.move = 1'b1; m.mode = MODE_FADE_IN; end
                    REQ_FORCE_ON: begin m.move = 1'b1; m.mode = MODE_ON; end
                    default: ;
                endcase
            end
            MODE_ON: begin
                case (t_request'(req)) inside
                    REQ_OFF:       begin m.move = 1'b1; m.mode = MODE_FADE_OFF; end
                    REQ_FORCE_OFF: begin m.move = 1'b1; m.mode = MODE_OFF; end
                    default: ;
                endcase
            end
            MODE_FADE_IN, MODE_FADE_OFF: begin
                case (t_request'(req)) inside
                    REQ_OFF, REQ_FORCE_OFF: begin m.move = 1'b1; m.mode = MODE_OFF; end
                    REQ_FORCE_ON:           begin m.move = 1'b1; m.mode = MODE_ON; end
                    default: ;
                endcase
            end
            default: ;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

// ===== src/lfsm_if.sv =====
// Valid/ready channel interfaces: request ticks in, duty writes out.
`default_nettype none

interface lfsm_req_if;
    import lfsm_pkg::*;

    logic             valid;
    logic             ready;
    logic [REQ_W-1:0] request;

    modport source (output valid, output request, input ready);
    modport sink   (input valid, input request, output ready);
endinterface

interface lfsm_duty_if #(
    parameter int DUTY_WIDTH = lfsm_pkg::DUTY_WIDTH_DEF
);
    import lfsm_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [DUTY_WIDTH-1:0] duty;
    logic [STATE_W-1:0]    led_state;
    logic                  last;

    modport source (output valid, output duty, output led_state, output last, input ready);
    modport sink   (input valid, input duty, input led_state, input last, output ready);
endinterface

`default_nettype wire

// ===== src/lfsm_div.sv =====
// Bit-serial restoring divider: one quotient bit per cycle.
`default_nettype none

module lfsm_div #(
    parameter int NUM_W = 26,
    parameter int DEN_W = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic [NUM_W-1:0] o_quo,
    output logic             o_done
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] r_num;   // dividend shifts out, quotient shifts in
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             fits;

    // Trial subtraction of one step
    always_comb begin
        trial = {r_rem, r_num[NUM_W-1]};
        diff  = trial - {1'b0, r_den};
        fits  = (trial >= {1'b0, r_den});
    end

    // Step counter and completion pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Shift registers
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_num <= {r_num[NUM_W-2:0], fits};
            r_rem <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        end
    end

    assign o_quo  = r_num;
    assign o_done = r_done;

endmodule

`default_nettype wire

// ===== src/lfsm_mul.sv =====
// Bit-serial shift-add multiplier: one multiplier bit per cycle, MSB first.
`default_nettype none

module lfsm_mul #(
    parameter int A_W = 26,
    parameter int B_W = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [A_W-1:0]     i_a,
    input  logic [B_W-1:0]     i_b,
    output logic [A_W+B_W-1:0] o_prod,
    output logic               o_done
);
    localparam int P_W   = A_W + B_W;
    localparam int CNT_W = $clog2(B_W + 1);

    logic [A_W-1:0]   r_a;
    logic [B_W-1:0]   r_b;
    logic [P_W-1:0]   r_acc;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [P_W-1:0]   addend;

    assign addend = r_b[B_W-1] ? {{B_W{1'b0}}, r_a} : '0;

    // Step counter and completion pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(B_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Accumulate: acc = 2*acc + bit*a
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_acc <= '0;
        end else if (r_busy) begin
            r_b   <= {r_b[B_W-2:0], 1'b0};
            r_acc <= {r_acc[P_W-2:0], 1'b0} + addend;
        end
    end

    assign o_prod = r_acc;
    assign o_done = r_done;

endmodule

`default_nettype wire

// ===== src/led_fade_state_machine.sv =====
// LED fade controller top level: tick divider, mode state machine, ramp unit, output stage.
//
// Usage:
//   i_req carries one tick per item with a request code. Every tick_period-th
//   tick the mode machine (off, fade in, on, fade off) takes one step and
//   writes zero, one or two PWM duties on o_duty; last marks the final write
//   of a tick and led_state gives the mode after the tick.
//   Configuration goes through i_cfg_wr_en / i_cfg_addr / i_cfg_wdata while
//   the block is idle; a tick_period of zero disables stepping (ticks are still taken).
// Sequence:
//   A tick that does not step is taken in idle; a step without a write returns
//   to idle, and one with only fixed writes goes on to send them. A fade ramp
//   write goes through the serial divider and then the serial multiplier.
//   One tick is in work at a time.
// Reset:
//   Synchronous, active low: mode off, counters cleared, registers at their
//   reset values, output empty.
// Stall:
//   Results wait in a one-entry output register; the next tick is accepted
//   once the last write of the current tick has entered that register.
`default_nettype none

module led_fade_state_machine #(
    parameter int DUTY_WIDTH = lfsm_pkg::DUTY_WIDTH_DEF,
    parameter int STEP_WIDTH = lfsm_pkg::STEP_WIDTH_DEF,
    parameter int FRAC_BITS  = lfsm_pkg::FRAC_BITS_DEF,
    localparam int DS_W  = (DUTY_WIDTH > STEP_WIDTH) ? DUTY_WIDTH : STEP_WIDTH,
    localparam int CFG_W = (DS_W > lfsm_pkg::PERIOD_W) ? DS_W : lfsm_pkg::PERIOD_W
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [lfsm_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_W-1:0]                i_cfg_wdata,
    lfsm_req_if.sink                        i_req,
    lfsm_duty_if.source                     o_duty
);
    import lfsm_pkg::*;

    localparam int NUM_W = DUTY_WIDTH + FRAC_BITS;
    localparam int P_W   = NUM_W + STEP_WIDTH;
    localparam int R_W   = DUTY_WIDTH + STEP_WIDTH;

    // Configuration registers
    logic [PERIOD_W-1:0]   r_tick_period;
    logic [STEP_WIDTH-1:0] r_fade_in_steps;
    logic [STEP_WIDTH-1:0] r_fade_off_steps;
    logic [DUTY_WIDTH-1:0] r_duty_min;
    logic [DUTY_WIDTH-1:0] r_duty_max;

    // Control state
    t_seq_state            r_seq, n_seq;
    t_led_mode             r_mode, n_mode;
    logic [PERIOD_W-1:0]   r_tick_count;
    logic [STEP_WIDTH-1:0] r_fade_count, n_fade_count;
    logic [REQ_W-1:0]      r_req;
    logic [DUTY_WIDTH-1:0] r_wr [2];
    logic [DUTY_WIDTH-1:0] n_wr [2];
    logic [1:0]            r_wr_cnt, n_wr_cnt;
    logic                  r_send_idx;

    // Output register
    logic                  r_out_valid;
    logic [DUTY_WIDTH-1:0] r_out_duty;
    t_led_mode             r_out_state;
    logic                  r_out_last;

    // Handshakes and sequencer controls
    logic                  in_ready;
    logic                  accept;
    logic [PERIOD_W-1:0]   tick_inc;
    logic                  tick_fire;
    logic                  div_start, div_done;
    logic                  mul_start, mul_done;
    logic                  out_load;
    logic                  send_last;

    // Step evaluation
    t_move                 step_move;
    logic                  step_ramp;
    logic [STEP_WIDTH-1:0] step_steps;
    logic [DUTY_WIDTH-1:0] step_span;

    // Ramp datapath
    logic [NUM_W-1:0]      div_quo;
    logic [P_W-1:0]        mul_prod;
    logic [R_W-1:0]        ramp;
    logic [R_W-1:0]        max_ext, min_ext;
    logic [R_W-1:0]        fade_val;
    logic [DUTY_WIDTH-1:0] fin_duty;

    // Tick divider
    assign accept    = i_req.valid && in_ready;
    assign tick_inc  = r_tick_count + PERIOD_W'(1);
    assign tick_fire = (r_tick_period != '0) && (tick_inc >= r_tick_period);

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_period    <= PERIOD_W'(1);
            r_fade_in_steps  <= STEP_WIDTH'(100);
            r_fade_off_steps <= STEP_WIDTH'(100);
            r_duty_min       <= '0;
            r_duty_max       <= '1;
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_addr'(i_cfg_addr))
                CFG_TICK_PERIOD:    r_tick_period    <= i_cfg_wdata[PERIOD_W-1:0];
                CFG_FADE_IN_STEPS:  r_fade_in_steps  <= i_cfg_wdata[STEP_WIDTH-1:0];
                CFG_FADE_OFF_STEPS: r_fade_off_steps <= i_cfg_wdata[STEP_WIDTH-1:0];
                CFG_DUTY_MIN:       r_duty_min       <= i_cfg_wdata[DUTY_WIDTH-1:0];
                CFG_DUTY_MAX:       r_duty_max       <= i_cfg_wdata[DUTY_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    // One mode step: transition with exit/entry actions, then the fade action
    always_comb begin
        n_mode       = r_mode;
        n_fade_count = r_fade_count;
        n_wr[0]      = '0;
        n_wr[1]      = '0;
        n_wr_cnt     = '0;
        step_ramp    = 1'b0;
        step_steps   = r_fade_in_steps;
        step_move    = lookup_move(r_mode, r_req);

        if (step_move.move) begin
            // exit action
            if (n_mode == MODE_FADE_IN) begin
                n_fade_count = '0;
            end else if (n_mode == MODE_FADE_OFF) begin
                n_wr[n_wr_cnt[0]] = '0;
                n_wr_cnt          = n_wr_cnt + 2'd1;
            end
            // entry action
            n_mode = step_move.mode;
            if (n_mode == MODE_OFF) begin
                n_wr[n_wr_cnt[0]] = '0;
                n_wr_cnt          = n_wr_cnt + 2'd1;
            end else if (n_mode == MODE_ON) begin
                n_wr[n_wr_cnt[0]] = r_duty_max;
                n_wr_cnt          = n_wr_cnt + 2'd1;
            end else begin
                n_fade_count = '0;
            end
        end

        // fade action
        if (n_mode == MODE_FADE_IN || n_mode == MODE_FADE_OFF) begin
            n_fade_count = n_fade_count + STEP_WIDTH'(1);
            step_steps   = (n_mode == MODE_FADE_IN) ? r_fade_in_steps : r_fade_off_steps;
            if (n_fade_count >= step_steps) begin
                if (n_mode == MODE_FADE_IN) begin
                    n_fade_count      = '0;
                    n_mode            = MODE_ON;
                    n_wr[n_wr_cnt[0]] = r_duty_max;
                    n_wr_cnt          = n_wr_cnt + 2'd1;
                end else begin
                    n_wr[n_wr_cnt[0]] = '0;
                    n_wr_cnt          = n_wr_cnt + 2'd1;
                    n_mode            = MODE_OFF;
                    n_wr[n_wr_cnt[0]] = '0;
                    n_wr_cnt          = n_wr_cnt + 2'd1;
                end
            end else begin
                step_ramp = 1'b1;
            end
        end
    end

    // Ramp span, zero for inverted bounds
    assign step_span = (r_duty_max > r_duty_min) ? (r_duty_max - r_duty_min) : '0;

    // Quotient (span << FRAC_BITS) / steps
    lfsm_div #(
        .NUM_W (NUM_W),
        .DEN_W (STEP_WIDTH)
    ) u_lfsm_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   ({step_span, {FRAC_BITS{1'b0}}}),
        .i_den   (step_steps),
        .o_quo   (div_quo),
        .o_done  (div_done)
    );

    // Quotient times fade count
    lfsm_mul #(
        .A_W (NUM_W),
        .B_W (STEP_WIDTH)
    ) u_lfsm_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (div_quo),
        .i_b     (r_fade_count),
        .o_prod  (mul_prod),
        .o_done  (mul_done)
    );

    // Fade duty: rising or falling ramp, then clamp (upper bound first)
    always_comb begin
        ramp    = mul_prod[P_W-1:FRAC_BITS];
        max_ext = {{STEP_WIDTH{1'b0}}, r_duty_max};
        min_ext = {{STEP_WIDTH{1'b0}}, r_duty_min};
        if (r_mode == MODE_FADE_IN) begin
            fade_val = ramp;
        end else begin
            fade_val = (ramp > max_ext) ? '0 : (max_ext - ramp);
        end
        if (fade_val > max_ext) begin
            fin_duty = r_duty_max;
        end else if (fade_val < min_ext) begin
            fin_duty = r_duty_min;
        end else begin
            fin_duty = fade_val[DUTY_WIDTH-1:0];
        end
    end

    // Sequencer next state
    always_comb begin
        n_seq = r_seq;
        unique case (r_seq)
            SEQ_IDLE: if (accept && tick_fire) n_seq = SEQ_STEP;
            SEQ_STEP: begin
                if (step_ramp) begin
                    n_seq = SEQ_DIV;
                end else if (n_wr_cnt != 2'd0) begin
                    n_seq = SEQ_SEND;
                end else begin
                    n_seq = SEQ_IDLE;
                end
            end
            SEQ_DIV:  if (div_done) n_seq = SEQ_MUL;
            SEQ_MUL:  if (mul_done) n_seq = SEQ_FIN;
            SEQ_FIN:  n_seq = SEQ_SEND;
            SEQ_SEND: if (out_load && send_last) n_seq = SEQ_IDLE;
            default:  n_seq = SEQ_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        in_ready  = 1'b0;
        div_start = 1'b0;
        mul_start = 1'b0;
        out_load  = 1'b0;
        send_last = ({1'b0, r_send_idx} + 2'd1) == r_wr_cnt;
        unique case (r_seq)
            SEQ_IDLE: in_ready  = 1'b1;
            SEQ_STEP: div_start = step_ramp;
            SEQ_DIV:  mul_start = div_done;
            SEQ_MUL:  ;
            SEQ_FIN:  ;
            SEQ_SEND: out_load  = !r_out_valid || o_duty.ready;
            default:  ;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq        <= SEQ_IDLE;
            r_mode       <= MODE_OFF;
            r_tick_count <= '0;
            r_fade_count <= '0;
            r_wr_cnt     <= '0;
            r_send_idx   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_seq <= n_seq;

            // tick counting on each accepted item
            if (accept) begin
                if (r_tick_period == '0 || tick_fire) begin
                    r_tick_count <= '0;
                end else begin
                    r_tick_count <= tick_inc;
                end
            end

            // commit the step
            if (r_seq == SEQ_STEP) begin
                r_mode       <= n_mode;
                r_fade_count <= n_fade_count;
                r_wr_cnt     <= n_wr_cnt;
                r_send_idx   <= 1'b0;
            end else if (r_seq == SEQ_FIN) begin
                r_wr_cnt <= r_wr_cnt + 2'd1;
            end else if (out_load) begin
                r_send_idx <= r_send_idx + 1'b1;
            end

            // output register valid
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_duty.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req <= i_req.request;
        end
        if (r_seq == SEQ_STEP) begin
            r_wr[0] <= n_wr[0];
            r_wr[1] <= n_wr[1];
        end else if (r_seq == SEQ_FIN) begin
            r_wr[r_wr_cnt[0]] <= fin_duty;
        end
        if (out_load) begin
            r_out_duty  <= r_wr[r_send_idx];
            r_out_state <= r_mode;
            r_out_last  <= send_last;
        end
    end

    // Channel outputs
    assign i_req.ready      = in_ready;
    assign o_duty.valid     = r_out_valid;
    assign o_duty.duty      = r_out_duty;
    assign o_duty.led_state = r_out_state;
    assign o_duty.last      = r_out_last;

endmodule

`default_nettype wire

// ===== src/lfsm_checker.sv =====
// Port-level checks for the LED fade controller, bound to the top level.
`default_nettype none

module lfsm_checker #(
    parameter int DUTY_WIDTH = lfsm_pkg::DUTY_WIDTH_DEF
) (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         i_in_valid,
    input wire logic                         i_in_ready,
    input wire logic                         i_out_valid,
    input wire logic                         i_out_ready,
    input wire logic [DUTY_WIDTH-1:0]        i_out_duty,
    input wire logic [lfsm_pkg::STATE_W-1:0] i_out_state,
    input wire logic                         i_out_last
);
    import lfsm_pkg::*;

    // Output register empties on reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    // A stalled item stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output item dropped while stalled");

    // A stalled item keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable({i_out_duty, i_out_state, i_out_last}))
        else $error("output payload changed while stalled");

    // No new tick is taken while the current tick still has a write pending
    a_busy_second: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_last |-> !(i_in_valid && i_in_ready))
        else $error("tick accepted while a tick has writes pending");

    // The second write of a tick follows at once and reports the same mode
    a_pair_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && !i_out_last
            |=> i_out_valid && (i_out_state == $past(i_out_state)))
        else $error("second write of a tick missing or mode differs");

endmodule

bind led_fade_state_machine lfsm_checker #(
    .DUTY_WIDTH (DUTY_WIDTH)
) u_lfsm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_req.valid),
    .i_in_ready  (i_req.ready),
    .i_out_valid (o_duty.valid),
    .i_out_ready (o_duty.ready),
    .i_out_duty  (o_duty.duty),
    .i_out_state (o_duty.led_state),
    .i_out_last  (o_duty.last)
);

`default_nettype wire
